// ===== hw/rtl/iff_pkg.sv =====
// Shared types, constants and helpers for the integer field formatter.
`default_nettype none

package iff_pkg;

    localparam int VALUE_BITS       = 64;
    localparam int NARROW_BITS      = 32;
    localparam int MODE_BITS        = 3;
    localparam int FIELD_WIDTH_BITS = 6;
    localparam int CHAR_BITS        = 8;

    localparam int MAX_FIELD_WIDTH  = 63;
    localparam int FW_SAT_BITS      = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int CNT_BITS         = (FW_SAT_BITS > FIELD_WIDTH_BITS) ?
                                      FW_SAT_BITS : FIELD_WIDTH_BITS;

    // Octal needs the most digits of the three radixes: 22 for 64 bits.
    localparam int NUM_DIGITS       = 22;
    localparam int DIG_BITS         = $clog2(NUM_DIGITS + 1);
    localparam int BCD_BITS         = 4 * NUM_DIGITS;
    localparam int STEP_BITS        = $clog2(VALUE_BITS + 1);

    localparam logic [MODE_BITS-1:0] MODE_DEC  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_UNS  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_OCT  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_HEXL = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_HEXU = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_CHR  = 3'd5;

    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;

    localparam logic [CHAR_BITS-1:0] LOWER_HEX [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [CHAR_BITS-1:0] UPPER_HEX [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_SHIFT,
        C_TRIM,
        C_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } fmt_state_t;

    typedef struct packed {
        logic   start;
        logic   take;
        radix_t radix;
        logic   narrow;
    } conv_cmd_t;

    typedef struct packed {
        logic                done;
        logic [DIG_BITS-1:0] ndig;
    } conv_stat_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d,
                                                        input logic upper);
        logic [CHAR_BITS-1:0] c;
        c = upper ? UPPER_HEX[d] : LOWER_HEX[d];
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/iff_req_if.sv =====
// Request channel: one integer conversion request per transfer.
`default_nettype none

interface iff_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [2:0]  mode;
    logic        wide;
    logic        left_align;
    logic        zero_pad;
    logic        force_plus;
    logic        space_sign;
    logic        alternate;
    logic [5:0]  field_width;

    modport source (
        output valid, value, mode, wide, left_align, zero_pad, force_plus,
               space_sign, alternate, field_width,
        input  ready
    );
    modport sink (
        input  valid, value, mode, wide, left_align, zero_pad, force_plus,
               space_sign, alternate, field_width,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/iff_res_if.sv =====
// Result channel: one formatted character per transfer.
`default_nettype none

interface iff_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (
        output valid, out_char, last,
        input  ready
    );
    modport sink (
        input  valid, out_char, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/integer_field_formatter.sv =====
// Top level of the integer field formatter: request decode, layout and character output.
//
//   channel  dir  payload                                               per transfer
//   req      in   value, mode, wide, flags, field_width                 one request
//   res      out  out_char, last                                        one character
//
// A number request takes N bit steps in the converter (N = 32 for a narrow operand, 64
// for a wide one), then a trim that drops leading zero digits (at most 21), then layout;
// a character request skips the converter. Characters then leave one per cycle unless
// res stalls, max(field_width, sign + prefix + digits) of them, through a single output
// register; the next request is taken the cycle after the last one is loaded. Reset
// clears all control state; a stall on res holds the output register.
`default_nettype none

module integer_field_formatter (
    input  logic      clk,
    input  logic      rst_n,
    iff_req_if.sink   req,
    iff_res_if.source res
);
    import iff_pkg::*;

    fmt_state_t            state_reg, state_next;
    logic                  left_reg, left_next;
    logic                  zero_reg, zero_next;
    logic                  upper_reg, upper_next;
    logic                  is_char_reg, is_char_next;
    logic                  sign_reg, sign_next;
    logic [1:0]            pre_reg, pre_next;
    logic [CNT_BITS-1:0]   width_reg, width_next;
    logic [CNT_BITS-1:0]   pad_reg, pad_next;
    logic [DIG_BITS-1:0]   dig_reg, dig_next;
    logic [CNT_BITS-1:0]   rem_reg, rem_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0]  char_reg, char_next;
    logic [CHAR_BITS-1:0]  sign_char_reg, sign_char_next;
    logic [CHAR_BITS-1:0]  out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    logic                  accept;
    logic                  mode_ok;
    logic                  is_dec;
    logic                  is_hex;
    logic [VALUE_BITS-1:0] narrow_val;
    logic [VALUE_BITS-1:0] uval;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [CNT_BITS-1:0]   fw_ext;
    logic [CNT_BITS-1:0]   total;
    logic [DIG_BITS-1:0]   ndig;
    logic                  emit_load;
    conv_cmd_t             cmd;
    conv_stat_t            stat;
    logic [3:0]            digit;

    iff_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .mag   (mag),
        .stat  (stat),
        .digit (digit)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // Request decode: operand extension, sign and magnitude.
    always_comb
    begin
        mode_ok    = (req.mode <= MODE_CHR);
        is_dec     = (req.mode == MODE_DEC);
        is_hex     = (req.mode == MODE_HEXL) || (req.mode == MODE_HEXU);
        narrow_val = {{(VALUE_BITS-NARROW_BITS){is_dec & req.value[NARROW_BITS-1]}},
                      req.value[NARROW_BITS-1:0]};
        uval       = req.wide ? req.value : narrow_val;
        neg        = is_dec && uval[VALUE_BITS-1];
        mag        = neg ? ('0 - uval) : uval;
        fw_ext     = CNT_BITS'(req.field_width);
    end

    always_comb
    begin
        cmd.start  = accept && mode_ok && (req.mode != MODE_CHR);
        cmd.narrow = !req.wide;
        if (is_dec || req.mode == MODE_UNS)
            cmd.radix = RADIX_DEC;
        else if (req.mode == MODE_OCT)
            cmd.radix = RADIX_OCT;
        else
            cmd.radix = RADIX_HEX;
        cmd.take = 1'b0;

        ndig  = is_char_reg ? DIG_BITS'(1) : stat.ndig;
        total = CNT_BITS'(ndig) + CNT_BITS'(sign_reg) + CNT_BITS'(pre_reg);

        emit_load = (state_reg == S_EMIT) && (!out_valid_reg || res.ready);

        state_next     = state_reg;
        left_next      = left_reg;
        zero_next      = zero_reg;
        upper_next     = upper_reg;
        is_char_next   = is_char_reg;
        sign_next      = sign_reg;
        pre_next       = pre_reg;
        width_next     = width_reg;
        pad_next       = pad_reg;
        dig_next       = dig_reg;
        rem_next       = rem_reg;
        char_next      = char_reg;
        sign_char_next = sign_char_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !res.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode_ok)
                begin
                    state_next   = S_CONV;
                    left_next    = req.left_align;
                    zero_next    = req.zero_pad;
                    upper_next   = (req.mode == MODE_HEXU);
                    is_char_next = (req.mode == MODE_CHR);
                    char_next    = req.value[CHAR_BITS-1:0];
                    sign_next    = is_dec && (neg || req.force_plus || req.space_sign);
                    if (neg)
                        sign_char_next = CH_MINUS;
                    else if (req.force_plus)
                        sign_char_next = CH_PLUS;
                    else
                        sign_char_next = CH_SPACE;
                    pre_next   = (is_hex && req.alternate && (uval != '0)) ? 2'd2 : 2'd0;
                    width_next = (fw_ext > CNT_BITS'(MAX_FIELD_WIDTH)) ?
                                 CNT_BITS'(MAX_FIELD_WIDTH) : fw_ext;
                end
            end
            S_CONV:
            begin
                if (is_char_reg || stat.done)
                begin
                    state_next = S_EMIT;
                    dig_next   = ndig;
                    if (width_reg > total)
                    begin
                        pad_next = width_reg - total;
                        rem_next = width_reg;
                    end
                    else
                    begin
                        pad_next = '0;
                        rem_next = total;
                    end
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = (rem_reg == CNT_BITS'(1));
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == CNT_BITS'(1))
                        state_next = S_IDLE;
                    if (!left_reg && !zero_reg && pad_reg != '0)
                    begin
                        out_char_next = CH_SPACE;
                        pad_next      = pad_reg - 1'b1;
                    end
                    else if (sign_reg)
                    begin
                        out_char_next = sign_char_reg;
                        sign_next     = 1'b0;
                    end
                    else if (pre_reg != 2'd0)
                    begin
                        if (pre_reg == 2'd2)
                            out_char_next = CH_ZERO;
                        else
                            out_char_next = upper_reg ? CH_UX : CH_LX;
                        pre_next = pre_reg - 1'b1;
                    end
                    else if (!left_reg && pad_reg != '0)
                    begin
                        out_char_next = CH_ZERO;
                        pad_next      = pad_reg - 1'b1;
                    end
                    else if (dig_reg != '0)
                    begin
                        out_char_next = is_char_reg ? char_reg : digit_char(digit, upper_reg);
                        dig_next      = dig_reg - 1'b1;
                        cmd.take      = !is_char_reg;
                    end
                    else
                    begin
                        out_char_next = CH_SPACE;
                        pad_next      = pad_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            upper_reg     <= 1'b0;
            is_char_reg   <= 1'b0;
            sign_reg      <= 1'b0;
            pre_reg       <= '0;
            width_reg     <= '0;
            pad_reg       <= '0;
            dig_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            zero_reg      <= zero_next;
            upper_reg     <= upper_next;
            is_char_reg   <= is_char_next;
            sign_reg      <= sign_next;
            pre_reg       <= pre_next;
            width_reg     <= width_next;
            pad_reg       <= pad_next;
            dig_reg       <= dig_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        sign_char_reg <= sign_char_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    assign res.valid    = out_valid_reg;
    assign res.out_char = out_char_reg;
    assign res.last     = out_last_reg;

    a_emit_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (rem_reg != '0))
        else $error("character count exhausted while emitting");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && rem_reg == CNT_BITS'(1)) |=> (state_reg == S_IDLE && res.last))
        else $error("final character did not close the field");

    a_digits_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (CNT_BITS'(dig_reg) <= rem_reg))
        else $error("more digits pending than characters left");

endmodule

`default_nettype wire

// ===== hw/rtl/iff_conv.sv =====
// Bit-serial radix converter: shift-and-adjust into 4-bit digit slots, then trim.
`default_nettype none

module iff_conv (
    input  logic               clk,
    input  logic               rst_n,
    input  iff_pkg::conv_cmd_t cmd,
    input  logic [63:0]        mag,
    output iff_pkg::conv_stat_t stat,
    output logic [3:0]         digit
);
    import iff_pkg::*;

    conv_state_t          state_reg, state_next;
    radix_t               radix_reg, radix_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic [DIG_BITS-1:0]  ndig_reg, ndig_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0]  bcd_reg, bcd_next;
    logic [BCD_BITS-1:0]  adj;
    logic [3:0]           half;
    logic [3:0]           offs;

    // Each slot that would reach the radix when doubled is pre-biased so the
    // doubling carries into the next slot.
    always_comb
    begin
        case (radix_reg)
            RADIX_DEC:
            begin
                half = 4'd5;
                offs = 4'd3;
            end
            RADIX_OCT:
            begin
                half = 4'd4;
                offs = 4'd4;
            end
            default:
            begin
                half = 4'd8;
                offs = 4'd0;
            end
        endcase
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= half)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + offs;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        radix_next = radix_reg;
        cnt_next   = cnt_reg;
        ndig_next  = ndig_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        if (cmd.start)
        begin
            state_next = C_SHIFT;
            radix_next = cmd.radix;
            bcd_next   = '0;
            if (cmd.narrow)
            begin
                mag_next = {mag[NARROW_BITS-1:0], {(VALUE_BITS-NARROW_BITS){1'b0}}};
                cnt_next = STEP_BITS'(NARROW_BITS);
            end
            else
            begin
                mag_next = mag;
                cnt_next = STEP_BITS'(VALUE_BITS);
            end
        end
        else
        begin
            case (state_reg)
                C_SHIFT:
                begin
                    bcd_next = {adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
                    mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == STEP_BITS'(1))
                    begin
                        state_next = C_TRIM;
                        ndig_next  = DIG_BITS'(NUM_DIGITS);
                    end
                end
                C_TRIM:
                begin
                    if (bcd_reg[BCD_BITS-1 -: 4] == 4'd0 && ndig_reg != DIG_BITS'(1))
                    begin
                        bcd_next  = {bcd_reg[BCD_BITS-5:0], 4'd0};
                        ndig_next = ndig_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = C_DONE;
                    end
                end
                C_DONE:
                begin
                    if (cmd.take)
                        bcd_next = {bcd_reg[BCD_BITS-5:0], 4'd0};
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            radix_reg <= RADIX_DEC;
            cnt_reg   <= '0;
            ndig_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            radix_reg <= radix_next;
            cnt_reg   <= cnt_next;
            ndig_reg  <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign stat.done = (state_reg == C_DONE);
    assign stat.ndig = ndig_reg;
    assign digit     = bcd_reg[BCD_BITS-1 -: 4];

    a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_SHIFT) |-> (cnt_reg != '0))
        else $error("bit step counter ran out during conversion");

    a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (state_reg == C_DONE))
        else $error("digit taken before conversion finished");

    a_trim_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_TRIM && !cmd.start && ndig_reg == DIG_BITS'(1))
        |=> (state_reg == C_DONE))
        else $error("trim went below one digit");

endmodule

`default_nettype wire
